/* design/curve25519_field_alu_unit_assert.svh */
// assertion macros for the field alu modules, included by cfa_carry
// expects clk and rst_n in the scope of each use
`ifndef CURVE25519_FIELD_ALU_UNIT_ASSERT_SVH
`define CURVE25519_FIELD_ALU_UNIT_ASSERT_SVH

// same-cycle implication
`define CFA_ASSERT_IMPL(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("field alu assertion failed");

// next-cycle implication
`define CFA_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("field alu assertion failed");

`endif

/* design/cfa_pkg.sv */
// types, constants and helpers for the radix 2^51 field alu
// no dependencies
`timescale 1ns / 1ps

package cfa_pkg;

    localparam int LIMB_BITS = 51;
    localparam int NUM_LIMBS = 5;

    localparam logic [63:0] TWICE_P_LOW  = 64'h000F_FFFF_FFFF_FFDA;
    localparam logic [63:0] TWICE_P_HIGH = 64'h000F_FFFF_FFFF_FFFE;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_SUB   = 2'd1,
        OP_CARRY = 2'd2,
        OP_MUL   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_PASS  = 2'd0,
        KIND_CARRY = 2'd1,
        KIND_MUL   = 2'd2
    } kind_t;

    typedef logic [63:0]  limb_t;
    typedef logic [127:0] wide_t;
    typedef logic [NUM_LIMBS-1:0][63:0]  elem_t;
    typedef logic [NUM_LIMBS-1:0][127:0] col_t;

    typedef struct packed {
        logic  valid;
        kind_t kind;
    } ctl_t;

    // x * 19 mod 2^64 as shift and add
    function automatic limb_t fold19(limb_t x);
        return (x << 4) + (x << 1) + x;
    endfunction

endpackage

/* design/cfa_in_if.sv */
// input channel of the field alu: operation and two five-limb operands
// depends on nothing
`timescale 1ns / 1ps

interface cfa_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [63:0] a_limb0;
    logic [63:0] a_limb1;
    logic [63:0] a_limb2;
    logic [63:0] a_limb3;
    logic [63:0] a_limb4;
    logic [63:0] b_limb0;
    logic [63:0] b_limb1;
    logic [63:0] b_limb2;
    logic [63:0] b_limb3;
    logic [63:0] b_limb4;

    modport source (
        output valid, operation, a_limb0, a_limb1, a_limb2, a_limb3, a_limb4,
        output b_limb0, b_limb1, b_limb2, b_limb3, b_limb4,
        input  ready
    );
    modport sink (
        input  valid, operation, a_limb0, a_limb1, a_limb2, a_limb3, a_limb4,
        input  b_limb0, b_limb1, b_limb2, b_limb3, b_limb4,
        output ready
    );
endinterface

/* design/cfa_out_if.sv */
// output channel of the field alu: one five-limb result
// depends on nothing
`timescale 1ns / 1ps

interface cfa_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_limb0;
    logic [63:0] result_limb1;
    logic [63:0] result_limb2;
    logic [63:0] result_limb3;
    logic [63:0] result_limb4;

    modport source (
        output valid, result_limb0, result_limb1, result_limb2, result_limb3, result_limb4,
        input  ready
    );
    modport sink (
        input  valid, result_limb0, result_limb1, result_limb2, result_limb3, result_limb4,
        output ready
    );
endinterface

/* design/cfa_mul.sv */
// operand stage, 32x32 partial products, product assembly and column sums
// depends on cfa_pkg
`timescale 1ns / 1ps

module cfa_mul (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  cfa_pkg::op_t   op,
    input  cfa_pkg::elem_t a,
    input  cfa_pkg::elem_t b,
    output cfa_pkg::ctl_t  col_ctl,
    output cfa_pkg::col_t  col
);
    import cfa_pkg::*;

    localparam int NPROD = NUM_LIMBS * NUM_LIMBS;

    ctl_t  s1_ctl_reg, s2_ctl_reg, s3_ctl_reg, s4_ctl_reg;
    ctl_t  s1_ctl_next;
    elem_t a_reg, b_reg, bf_reg;
    elem_t simple1_reg, simple2_reg, simple3_reg;
    elem_t simple_next, bf_next;
    logic [63:0] pp_reg [NPROD][4];
    logic [63:0] pp_next [NPROD][4];
    wide_t prod_reg [NPROD];
    wide_t prod_next [NPROD];
    col_t  col_reg, col_next;

    // stage 1 inputs: b*19 and the non-multiply result
    always_comb
    begin
        s1_ctl_next.valid = in_valid;
        case (op)
            OP_MUL:   s1_ctl_next.kind = KIND_MUL;
            OP_CARRY: s1_ctl_next.kind = KIND_CARRY;
            default:  s1_ctl_next.kind = KIND_PASS;
        endcase
        for (int i = 0; i < NUM_LIMBS; i++)
        begin
            bf_next[i] = fold19(b[i]);
            case (op)
                OP_ADD:  simple_next[i] = a[i] + b[i];
                OP_SUB:  simple_next[i] = a[i] + ((i == 0) ? TWICE_P_LOW : TWICE_P_HIGH) - b[i];
                default: simple_next[i] = a[i];
            endcase
        end
    end

    // stage 2: four 32x32 partials per limb product
    always_comb
    begin
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < NUM_LIMBS; i++)
        begin
            for (int j = 0; j < NUM_LIMBS; j++)
            begin
                if (i >= j)
                    m = b_reg[i-j];
                else
                    m = bf_reg[i-j+NUM_LIMBS];
                pp_next[i*NUM_LIMBS+j][0] = 64'(a_reg[j][31:0])  * 64'(m[31:0]);
                pp_next[i*NUM_LIMBS+j][1] = 64'(a_reg[j][31:0])  * 64'(m[63:32]);
                pp_next[i*NUM_LIMBS+j][2] = 64'(a_reg[j][63:32]) * 64'(m[31:0]);
                pp_next[i*NUM_LIMBS+j][3] = 64'(a_reg[j][63:32]) * 64'(m[63:32]);
            end
        end
    end

    // stage 3: assemble 128-bit products
    always_comb
    begin
        for (int p = 0; p < NPROD; p++)
        begin
            prod_next[p] = {pp_reg[p][3], pp_reg[p][0]}
                         + {32'd0, pp_reg[p][1], 32'd0}
                         + {32'd0, pp_reg[p][2], 32'd0};
        end
    end

    // stage 4: column sums, or the precomputed value for the other operations
    always_comb
    begin
        for (int i = 0; i < NUM_LIMBS; i++)
        begin
            if (s3_ctl_reg.kind == KIND_MUL)
                col_next[i] = prod_reg[i*NUM_LIMBS] + prod_reg[i*NUM_LIMBS+1]
                            + prod_reg[i*NUM_LIMBS+2] + prod_reg[i*NUM_LIMBS+3]
                            + prod_reg[i*NUM_LIMBS+4];
            else
                col_next[i] = {64'd0, simple3_reg[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
            s4_ctl_reg <= '0;
        end
        else if (en)
        begin
            s1_ctl_reg <= s1_ctl_next;
            s2_ctl_reg <= s1_ctl_reg;
            s3_ctl_reg <= s2_ctl_reg;
            s4_ctl_reg <= s3_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg       <= a;
            b_reg       <= b;
            bf_reg      <= bf_next;
            simple1_reg <= simple_next;
            simple2_reg <= simple1_reg;
            simple3_reg <= simple2_reg;
            pp_reg      <= pp_next;
            prod_reg    <= prod_next;
            col_reg     <= col_next;
        end
    end

    assign col_ctl = s4_ctl_reg;
    assign col     = col_reg;

endmodule

/* design/cfa_carry.sv */
// carry chain over the column values, top fold and final fold into limb 1
// depends on cfa_pkg and curve25519_field_alu_unit_assert.svh
`timescale 1ns / 1ps

module cfa_carry (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  cfa_pkg::ctl_t  in_ctl,
    input  cfa_pkg::col_t  col,
    output cfa_pkg::ctl_t  out_ctl,
    output cfa_pkg::elem_t result
);
    import cfa_pkg::*;
    `include "curve25519_field_alu_unit_assert.svh"

    typedef struct packed {
        limb_t r;
        limb_t c;
    } step_t;

    // one limb of the chain; carry wraps the sum at 64 bits, multiply at 128
    function automatic step_t chain_step(kind_t kind, wide_t x, limb_t c);
        wide_t t;
        step_t s;
        case (kind)
            KIND_CARRY: t = {64'd0, x[63:0] + c};
            KIND_MUL:   t = x + {64'd0, c};
            default:    t = x;
        endcase
        if (kind == KIND_PASS)
            s.r = x[63:0];
        else
            s.r = {{(64-LIMB_BITS){1'b0}}, t[LIMB_BITS-1:0]};
        s.c = t[LIMB_BITS+63:LIMB_BITS];
        return s;
    endfunction

    ctl_t  s5_ctl_reg, s6_ctl_reg, s7_ctl_reg, s8_ctl_reg;
    elem_t r5_reg, r6_reg, r7_reg, r8_reg;
    elem_t r5_next, r6_next, r7_next, r8_next;
    limb_t c5_reg, c6_reg, c5_next, c6_next;
    col_t  col5_reg, col6_reg;
    step_t st0, st1, st2, st3, st4;

    always_comb
    begin
        st0 = chain_step(in_ctl.kind, col[0], 64'd0);
        st1 = chain_step(in_ctl.kind, col[1], st0.c);
        r5_next    = '0;
        r5_next[0] = st0.r;
        r5_next[1] = st1.r;
        c5_next    = st1.c;
    end

    always_comb
    begin
        st2 = chain_step(s5_ctl_reg.kind, col5_reg[2], c5_reg);
        st3 = chain_step(s5_ctl_reg.kind, col5_reg[3], st2.c);
        r6_next    = r5_reg;
        r6_next[2] = st2.r;
        r6_next[3] = st3.r;
        c6_next    = st3.c;
    end

    // last limb, then top carry times 19 into limb 0
    always_comb
    begin
        st4 = chain_step(s6_ctl_reg.kind, col6_reg[4], c6_reg);
        r7_next    = r6_reg;
        r7_next[4] = st4.r;
        if (s6_ctl_reg.kind != KIND_PASS)
            r7_next[0] = r6_reg[0] + fold19(st4.c);
    end

    // multiply only: one more carry out of limb 0
    always_comb
    begin
        r8_next = r7_reg;
        if (s7_ctl_reg.kind == KIND_MUL)
        begin
            r8_next[0] = {{(64-LIMB_BITS){1'b0}}, r7_reg[0][LIMB_BITS-1:0]};
            r8_next[1] = r7_reg[1] + {{LIMB_BITS{1'b0}}, r7_reg[0][63:LIMB_BITS]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_ctl_reg <= '0;
            s6_ctl_reg <= '0;
            s7_ctl_reg <= '0;
            s8_ctl_reg <= '0;
        end
        else if (en)
        begin
            s5_ctl_reg <= in_ctl;
            s6_ctl_reg <= s5_ctl_reg;
            s7_ctl_reg <= s6_ctl_reg;
            s8_ctl_reg <= s7_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r5_reg   <= r5_next;
            r6_reg   <= r6_next;
            r7_reg   <= r7_next;
            r8_reg   <= r8_next;
            c5_reg   <= c5_next;
            c6_reg   <= c6_next;
            col5_reg <= col;
            col6_reg <= col5_reg;
        end
    end

    assign out_ctl = s8_ctl_reg;
    assign result  = r8_reg;

    `CFA_ASSERT_IMPL(a_mul_limb0_reduced, s8_ctl_reg.valid && s8_ctl_reg.kind == KIND_MUL,
        r8_reg[0][63:LIMB_BITS] == '0)
    `CFA_ASSERT_IMPL(a_chain_limbs_reduced, s8_ctl_reg.valid && s8_ctl_reg.kind != KIND_PASS,
        r8_reg[2][63:LIMB_BITS] == '0 && r8_reg[3][63:LIMB_BITS] == '0
        && r8_reg[4][63:LIMB_BITS] == '0)
    `CFA_ASSERT_NEXT(a_stall_holds_stage, !en, $stable(s6_ctl_reg) && $stable(r6_reg))

endmodule

/* design/curve25519_field_alu_unit.sv */
// usage: in_ch takes a transfer of operation plus operands a and b (five 64-bit
// limbs each, radix 2^51); out_ch gives one five-limb result per input transfer,
// in order. operations: add (a+b per limb), subtract (a+2p-b per limb), carry
// (51-bit carry chain over a, top carry times 19 into limb 0) and multiply
// (schoolbook with 19-fold, carry chain, final fold into limbs 0 and 1).
// pipeline: eight register stages; the input transfer edge loads the first, and
// out_ch.valid rises once the result reaches the eighth, the same for every operation.
// throughput: one transfer per cycle while out_ch is not stalling.
// the depth is set by the multiply path: operand and b*19 stage, 32x32 partial
// products, 128-bit product assembly, column sums, then two carry-chain stages
// of two limbs each, the last limb with the top fold, and the final fold.
// reset (rst_n low, async) clears every stage valid bit; data registers hold junk
// until overwritten. when out_ch stalls with a result waiting, the whole pipe
// freezes, bubbles included, and in_ch.ready drops in the same cycle; ready
// stays high as long as the output register is empty or being taken.
// depends on cfa_pkg, cfa_in_if, cfa_out_if, cfa_mul, cfa_carry
`timescale 1ns / 1ps

module curve25519_field_alu_unit (
    input  logic       clk,
    input  logic       rst_n,
    cfa_in_if.sink     in_ch,
    cfa_out_if.source  out_ch
);
    import cfa_pkg::*;

    logic  en;
    elem_t a, b, result;
    ctl_t  col_ctl, out_ctl;
    col_t  col;

    // all stages move together unless a result sits unclaimed at the output
    assign en          = !out_ctl.valid || out_ch.ready;
    assign in_ch.ready = en;

    assign a = {in_ch.a_limb4, in_ch.a_limb3, in_ch.a_limb2, in_ch.a_limb1, in_ch.a_limb0};
    assign b = {in_ch.b_limb4, in_ch.b_limb3, in_ch.b_limb2, in_ch.b_limb1, in_ch.b_limb0};

    // products and column sums (stages 1 to 4)
    cfa_mul u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_ch.valid),
        .op       (op_t'(in_ch.operation)),
        .a        (a),
        .b        (b),
        .col_ctl  (col_ctl),
        .col      (col)
    );

    // carry chain and folds (stages 5 to 8, last is the output register)
    cfa_carry u_carry (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_ctl  (col_ctl),
        .col     (col),
        .out_ctl (out_ctl),
        .result  (result)
    );

    assign out_ch.valid        = out_ctl.valid;
    assign out_ch.result_limb0 = result[0];
    assign out_ch.result_limb1 = result[1];
    assign out_ch.result_limb2 = result[2];
    assign out_ch.result_limb3 = result[3];
    assign out_ch.result_limb4 = result[4];

endmodule
